>>> hdl/tfl_pkg.sv
// shared constants for the three-line triangle pipeline
// status codes, default widths and the coefficient product table; no dependencies
`timescale 1ns / 1ps

package tfl_pkg;

  localparam int COEF_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF = 16;
  localparam int AREA_FRAC     = 8;
  localparam int STAT_W        = 2;
  localparam int NUM_LINES     = 3;
  localparam int NUM_COEF      = 3 * NUM_LINES;
  localparam int NUM_PROD      = 18;
  localparam int NUM_DIFF      = NUM_PROD / 2;
  localparam int NUM_DIV       = 6;
  localparam int NUM_SIDE      = 3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_PAR12 = 2'd1;
  localparam logic [STAT_W-1:0] ST_PAR23 = 2'd2;
  localparam logic [STAT_W-1:0] ST_PAR13 = 2'd3;

  // coefficient index pairs, coefficients ordered a1 b1 c1 a2 b2 c2 a3 b3 c3
  // differences in pairs: d12 nx12 ny12 d23 nx23 ny23 d13 nx13 ny13
  localparam int PROD_L [NUM_PROD] = '{0, 1, 4, 1, 0, 3, 3, 4, 7, 4, 3, 6, 0, 1, 7, 1, 0, 6};
  localparam int PROD_R [NUM_PROD] = '{4, 3, 2, 5, 5, 2, 7, 6, 5, 8, 8, 5, 7, 6, 2, 8, 8, 2};

endpackage

>>> hdl/triangle_from_three_lines.sv
// triangle from three lines: intersections, side lengths and heron area
// fully pipelined, one bit of quotient or root per stage; uses tfl_pkg
// at 12 coefficient and 16 fraction bits the dividers have 40 stages,
//   the side roots 43 stages and the area root 90 stages
// throughput: one request per cycle; a stalled output holds the whole pipeline
// reset: rst_ni clears the stage valid bits only, data registers are not reset
`timescale 1ns / 1ps

module triangle_from_three_lines #(
  parameter int COEF_BITS = tfl_pkg::COEF_BITS_DEF,
  parameter int FRAC_BITS = tfl_pkg::FRAC_BITS_DEF,
  localparam int PT_W   = 2 * COEF_BITS + FRAC_BITS,
  localparam int SIDE_W = PT_W + 1,
  localparam int AREA_W = 4 * COEF_BITS + FRAC_BITS + 2 - tfl_pkg::AREA_FRAC,
  localparam int IN_W   = ((tfl_pkg::NUM_COEF * COEF_BITS + 7) / 8) * 8,
  localparam int OUT_W  = ((6 * PT_W + 3 * SIDE_W + AREA_W + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // line1_a line1_b line1_c line2_a line2_b line2_c line3_a line3_b line3_c
  input  logic [IN_W-1:0]             s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // p12_x p12_y p23_x p23_y p13_x p13_y side_first side_second side_third tri_area
  output logic [OUT_W-1:0]            m_axis_tdata,
  // status
  output logic [tfl_pkg::STAT_W-1:0]  m_axis_tuser
);
  import tfl_pkg::*;

  localparam int DF_W   = 2 * COEF_BITS + 1;
  localparam int MAG_W  = 2 * COEF_BITS;
  localparam int QB     = PT_W;
  localparam int NUM_W  = MAG_W + FRAC_BITS + 2;
  localparam int DEN_W  = MAG_W + 1;
  localparam int CMP_W  = QB + DEN_W;
  localparam int PX_W   = QB + 1;
  localparam int DX_W   = QB + 2;
  localparam int SQ_H   = (DX_W + 1) / 2;
  localparam int SQ_HI  = DX_W - SQ_H;
  localparam int SR     = DX_W + 1;
  localparam int SRAD   = 2 * SR;
  localparam int T_W    = SR + 2;
  localparam int TH     = (T_W + 1) / 2;
  localparam int THI    = T_W - TH;
  localparam int PR_W   = 2 * T_W;
  localparam int CK     = (PR_W + 3) / 4;
  localparam int ROW_W  = CK + PR_W;
  localparam int HP_W   = 4 * T_W;
  localparam int AR     = 2 * T_W;
  localparam int AREA_K = 2 * FRAC_BITS + 2 - AREA_FRAC;

  // stage positions
  localparam int L_DE = 2 + QB;
  localparam int L_P  = L_DE + 1;
  localparam int L_D  = L_P + 1;
  localparam int L_M  = L_D + 1;
  localparam int L_S  = L_M + 1;
  localparam int L_R  = L_S + 1;
  localparam int L_V  = L_R + SR + 1;
  localparam int L_T  = L_V + 1;
  localparam int L_H1 = L_T + 1;
  localparam int L_H2 = L_H1 + 1;
  localparam int L_H3 = L_H2 + 1;
  localparam int L_H4 = L_H3 + 1;
  localparam int L_H5 = L_H4 + 1;
  localparam int LAST = L_H5 + AR + 1;

  localparam int N_STC = LAST - 2;
  localparam int N_PTC = LAST - L_P;
  localparam int N_SDC = LAST - L_V;
  localparam int N_NGC = LAST - L_T;

  logic en;
  logic vld_q [LAST+1];

  // pipeline advances unless the output holds an untaken result
  assign en            = m_axis_tready | ~vld_q[LAST];
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAST];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LAST; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i <= LAST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // ---------------- front: products, determinants, divider set-up ----------------
  logic signed [COEF_BITS-1:0] c_q    [NUM_COEF];
  logic signed [MAG_W-1:0]     prod_q [NUM_PROD];
  logic signed [DF_W-1:0]      df     [NUM_DIFF];
  logic [DF_W-1:0]             dfa_w  [NUM_DIFF];
  logic [MAG_W-1:0]            dfa    [NUM_DIFF];
  logic [STAT_W-1:0]           stat_d;
  logic [STAT_W-1:0]           stc_q  [N_STC];

  logic [NUM_W-1:0] rem_q  [QB+1][NUM_DIV];
  logic [QB-1:0]    quo_q  [QB+1][NUM_DIV];
  logic [DEN_W-1:0] dvs_q  [QB+1][NUM_SIDE];
  logic             neg_q  [QB+1][NUM_DIV];
  logic [NUM_W-1:0] rem_init [NUM_DIV];
  logic [DEN_W-1:0] dvs_init [NUM_SIDE];
  logic             neg_init [NUM_DIV];

  for (genvar k = 0; k < NUM_DIFF; k++) begin : g_diff
    assign df[k]    = DF_W'(prod_q[2*k]) - DF_W'(prod_q[2*k+1]);
    assign dfa_w[k] = df[k][DF_W-1] ? -df[k] : df[k];
    assign dfa[k]   = dfa_w[k][MAG_W-1:0];
  end

  // first parallel pair wins
  always_comb begin
    priority if (df[0] == '0) stat_d = ST_PAR12;
    else if (df[3] == '0)     stat_d = ST_PAR23;
    else if (df[6] == '0)     stat_d = ST_PAR13;
    else                      stat_d = ST_OK;
  end

  // dividend is 2*|num|*2^F + |den|, divisor 2*|den|: nearest, ties away from zero
  for (genvar g = 0; g < NUM_DIV; g++) begin : g_dinit
    localparam int P  = g / 2;
    localparam int NI = 3 * P + 1 + (g % 2);
    localparam int DI = 3 * P;
    assign rem_init[g] = (NUM_W'(dfa[NI]) << (FRAC_BITS + 1)) + NUM_W'(dfa[DI]);
    assign neg_init[g] = df[NI][DF_W-1] ^ df[DI][DF_W-1];
  end
  for (genvar p = 0; p < NUM_SIDE; p++) begin : g_den
    assign dvs_init[p] = DEN_W'(dfa[3*p]) << 1;
  end

  // restoring divider, one quotient bit per stage
  logic [CMP_W-1:0] dv_trial [QB][NUM_DIV];
  logic             dv_ge    [QB][NUM_DIV];
  for (genvar j = 1; j <= QB; j++) begin : g_dstage
    for (genvar g = 0; g < NUM_DIV; g++) begin : g_dlane
      assign dv_trial[j-1][g] = CMP_W'(dvs_q[j-1][g/2]) << (QB - j);
      assign dv_ge[j-1][g]    = CMP_W'(rem_q[j-1][g]) >= dv_trial[j-1][g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NUM_COEF; i++) c_q[i] <= s_axis_tdata[i*COEF_BITS +: COEF_BITS];
      for (int i = 0; i < NUM_PROD; i++) prod_q[i] <= c_q[PROD_L[i]] * c_q[PROD_R[i]];
      stc_q[0] <= stat_d;
      for (int i = 1; i < N_STC; i++) stc_q[i] <= stc_q[i-1];
      for (int g = 0; g < NUM_DIV; g++) begin
        rem_q[0][g] <= rem_init[g];
        quo_q[0][g] <= '0;
        neg_q[0][g] <= neg_init[g];
      end
      for (int p = 0; p < NUM_SIDE; p++) dvs_q[0][p] <= dvs_init[p];
      for (int j = 1; j <= QB; j++) begin
        for (int g = 0; g < NUM_DIV; g++) begin
          rem_q[j][g] <= dv_ge[j-1][g] ?
                         rem_q[j-1][g] - dv_trial[j-1][g][NUM_W-1:0] : rem_q[j-1][g];
          quo_q[j][g] <= quo_q[j-1][g] | (QB'(dv_ge[j-1][g]) << (QB - j));
          neg_q[j][g] <= neg_q[j-1][g];
        end
        for (int p = 0; p < NUM_SIDE; p++) dvs_q[j][p] <= dvs_q[j-1][p];
      end
    end
  end

  // ---------------- points and side lengths ----------------
  logic [PX_W-1:0]     ptc_q [N_PTC][NUM_DIV];
  logic [PX_W-1:0]     pt_d  [NUM_DIV];
  logic signed [DX_W-1:0] dd_w [2*NUM_SIDE];
  logic [DX_W-1:0]     dd_d  [2*NUM_SIDE];
  logic [DX_W-1:0]     dd_q  [2*NUM_SIDE];
  logic [2*SQ_H-1:0]   ll_q  [2*NUM_SIDE];
  logic [SQ_H+SQ_HI-1:0] lh_q [2*NUM_SIDE];
  logic [2*SQ_HI-1:0]  hh_q  [2*NUM_SIDE];
  logic [2*DX_W-1:0]   sq_q  [2*NUM_SIDE];

  for (genvar g = 0; g < NUM_DIV; g++) begin : g_pt
    assign pt_d[g] = neg_q[QB][g] ? -PX_W'(quo_q[QB][g]) : PX_W'(quo_q[QB][g]);
  end

  // sides: p12 to p23, p23 to p13, p12 to p13
  for (genvar s = 0; s < NUM_SIDE; s++) begin : g_dd
    localparam int PA = (s == 1) ? 1 : 0;
    localparam int PB = (s == 0) ? 1 : 2;
    for (genvar a = 0; a < 2; a++) begin : g_ax
      assign dd_w[2*s+a] = $signed({ptc_q[0][2*PA+a][PX_W-1], ptc_q[0][2*PA+a]})
                         - $signed({ptc_q[0][2*PB+a][PX_W-1], ptc_q[0][2*PB+a]});
      assign dd_d[2*s+a] = dd_w[2*s+a][DX_W-1] ? DX_W'(-dd_w[2*s+a]) : DX_W'(dd_w[2*s+a]);
    end
  end

  logic [SRAD-1:0] srem_q  [SR+1][NUM_SIDE];
  logic [SR-1:0]   sroot_q [SR+1][NUM_SIDE];
  logic [SRAD-1:0] sq_trial [SR][NUM_SIDE];
  logic            sq_ge    [SR][NUM_SIDE];

  // square root by remainder: trial is (root << (b+1)) + 4^b
  for (genvar j = 1; j <= SR; j++) begin : g_sstage
    for (genvar s = 0; s < NUM_SIDE; s++) begin : g_slane
      assign sq_trial[j-1][s] = (SRAD'(sroot_q[j-1][s]) << (SR - j + 1))
                              | (SRAD'(1) << (2 * (SR - j)));
      assign sq_ge[j-1][s]    = srem_q[j-1][s] >= sq_trial[j-1][s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int g = 0; g < NUM_DIV; g++) begin
        ptc_q[0][g] <= pt_d[g];
        for (int i = 1; i < N_PTC; i++) ptc_q[i][g] <= ptc_q[i-1][g];
      end
      for (int i = 0; i < 2*NUM_SIDE; i++) begin
        dd_q[i] <= dd_d[i];
        ll_q[i] <= dd_q[i][SQ_H-1:0] * dd_q[i][SQ_H-1:0];
        lh_q[i] <= dd_q[i][SQ_H-1:0] * dd_q[i][DX_W-1:SQ_H];
        hh_q[i] <= dd_q[i][DX_W-1:SQ_H] * dd_q[i][DX_W-1:SQ_H];
        sq_q[i] <= (2*DX_W)'(ll_q[i]) + ((2*DX_W)'(lh_q[i]) << (SQ_H + 1))
                 + ((2*DX_W)'(hh_q[i]) << (2 * SQ_H));
      end
      for (int s = 0; s < NUM_SIDE; s++) begin
        srem_q[0][s]  <= SRAD'(sq_q[2*s]) + SRAD'(sq_q[2*s+1]);
        sroot_q[0][s] <= '0;
        for (int j = 1; j <= SR; j++) begin
          srem_q[j][s]  <= sq_ge[j-1][s] ? srem_q[j-1][s] - sq_trial[j-1][s] : srem_q[j-1][s];
          sroot_q[j][s] <= sroot_q[j-1][s] | (SR'(sq_ge[j-1][s]) << (SR - j));
        end
      end
    end
  end

  // ---------------- heron area ----------------
  logic [SR-1:0]          sdc_q [N_SDC][NUM_SIDE];
  logic [SR-1:0]          side_d [NUM_SIDE];
  logic                   ngc_q [N_NGC];
  logic signed [T_W:0]    tt [4];
  logic [T_W-1:0]         t_q [4];
  logic [2*TH-1:0]        pll_q [2];
  logic [TH+THI-1:0]      plh_q [2];
  logic [TH+THI-1:0]      phl_q [2];
  logic [2*THI-1:0]       phh_q [2];
  logic [PR_W-1:0]        pr_q  [2];
  logic [4*CK-1:0]        pa_ext, pb_ext;
  logic [2*CK-1:0]        pp_q  [4][4];
  logic [ROW_W-1:0]       row_q [4];
  logic [HP_W-1:0]        hrad;

  for (genvar s = 0; s < NUM_SIDE; s++) begin : g_round
    assign side_d[s] = sroot_q[SR][s] + SR'(srem_q[SR][s] > SRAD'(sroot_q[SR][s]));
  end

  // four factors of 16 times the squared area, all in units of a side lsb
  always_comb begin
    tt[0] = $signed({2'b00, sdc_q[0][0]}) + $signed({2'b00, sdc_q[0][1]})
          + $signed({2'b00, sdc_q[0][2]});
    tt[1] = $signed({2'b00, sdc_q[0][1]}) + $signed({2'b00, sdc_q[0][2]})
          - $signed({2'b00, sdc_q[0][0]});
    tt[2] = $signed({2'b00, sdc_q[0][0]}) + $signed({2'b00, sdc_q[0][2]})
          - $signed({2'b00, sdc_q[0][1]});
    tt[3] = $signed({2'b00, sdc_q[0][0]}) + $signed({2'b00, sdc_q[0][1]})
          - $signed({2'b00, sdc_q[0][2]});
  end

  assign pa_ext = (4*CK)'(pr_q[0]);
  assign pb_ext = (4*CK)'(pr_q[1]);

  // wide product from a grid of chunk products
  always_comb begin
    hrad = '0;
    for (int i = 0; i < 4; i++) hrad = hrad + (HP_W'(row_q[i]) << (CK * i));
  end

  logic [HP_W-1:0] arem_q  [AR+1];
  logic [AR-1:0]   aroot_q [AR+1];
  logic [HP_W-1:0] ar_trial [AR];
  logic            ar_ge    [AR];

  for (genvar j = 1; j <= AR; j++) begin : g_astage
    assign ar_trial[j-1] = (HP_W'(aroot_q[j-1]) << (AR - j + 1)) | (HP_W'(1) << (2 * (AR - j)));
    assign ar_ge[j-1]    = arem_q[j-1] >= ar_trial[j-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NUM_SIDE; s++) begin
        sdc_q[0][s] <= side_d[s];
        for (int i = 1; i < N_SDC; i++) sdc_q[i][s] <= sdc_q[i-1][s];
      end
      ngc_q[0] <= tt[1][T_W] | tt[2][T_W] | tt[3][T_W];
      for (int i = 1; i < N_NGC; i++) ngc_q[i] <= ngc_q[i-1];
      for (int i = 0; i < 4; i++) t_q[i] <= tt[i][T_W-1:0];
      for (int h = 0; h < 2; h++) begin
        pll_q[h] <= t_q[2*h][TH-1:0]     * t_q[2*h+1][TH-1:0];
        plh_q[h] <= t_q[2*h][TH-1:0]     * t_q[2*h+1][T_W-1:TH];
        phl_q[h] <= t_q[2*h][T_W-1:TH]   * t_q[2*h+1][TH-1:0];
        phh_q[h] <= t_q[2*h][T_W-1:TH]   * t_q[2*h+1][T_W-1:TH];
        pr_q[h]  <= PR_W'(pll_q[h]) + ((PR_W'(plh_q[h]) + PR_W'(phl_q[h])) << TH)
                  + (PR_W'(phh_q[h]) << (2 * TH));
      end
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) pp_q[i][j] <= pa_ext[CK*i +: CK] * pb_ext[CK*j +: CK];
        row_q[i] <= ROW_W'(pp_q[i][0]) + (ROW_W'(pp_q[i][1]) << CK)
                  + (ROW_W'(pp_q[i][2]) << (2 * CK)) + (ROW_W'(pp_q[i][3]) << (3 * CK));
      end
      arem_q[0]  <= hrad;
      aroot_q[0] <= '0;
      for (int j = 1; j <= AR; j++) begin
        arem_q[j]  <= ar_ge[j-1] ? arem_q[j-1] - ar_trial[j-1] : arem_q[j-1];
        aroot_q[j] <= aroot_q[j-1] | (AR'(ar_ge[j-1]) << (AR - j));
      end
    end
  end

  // ---------------- output register ----------------
  logic [AR:0]         area_sum;
  logic [AR:0]         area_shift;
  logic [STAT_W-1:0]   out_stat_q;
  logic [PT_W-1:0]     out_pt_q   [NUM_DIV];
  logic [SIDE_W-1:0]   out_side_q [NUM_SIDE];
  logic [AREA_W-1:0]   out_area_q;
  logic                bad;

  assign area_sum   = (AR+1)'(aroot_q[AR]) + ((AR+1)'(1) << (AREA_K - 1));
  assign area_shift = area_sum >> AREA_K;
  assign bad        = stc_q[N_STC-1] != ST_OK;

  // parallel lines zero every geometric field
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_stat_q <= stc_q[N_STC-1];
      for (int g = 0; g < NUM_DIV; g++)
        out_pt_q[g] <= bad ? '0 : ptc_q[N_PTC-1][g][PT_W-1:0];
      for (int s = 0; s < NUM_SIDE; s++)
        out_side_q[s] <= bad ? '0 : SIDE_W'(sdc_q[N_SDC-1][s]);
      out_area_q <= (bad | ngc_q[N_NGC-1]) ? '0 : AREA_W'(area_shift);
    end
  end

  assign m_axis_tuser = out_stat_q;
  assign m_axis_tdata = OUT_W'({out_area_q, out_side_q[2], out_side_q[1], out_side_q[0],
                                out_pt_q[5], out_pt_q[4], out_pt_q[3], out_pt_q[2],
                                out_pt_q[1], out_pt_q[0]});

endmodule
